### rtl/eht_pkg.sv
// shared widths, default sizes and codes of the extendible hash table
package eht_pkg;

    localparam int SLOTS_PER_BUCKET_DEF  = 4;
    localparam int BUCKET_INDEX_BITS_DEF = 4;
    localparam int MAX_GLOBAL_DEPTH_DEF  = 8;
    localparam int SEGMENT_POOL_DEF      = 64;

    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int KB_W       = 7;
    localparam int ID_W       = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [KB_W-1:0] KEY_BITS_RST = 7'd16;

    localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BITS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DEPTH = 1'b1;

endpackage

### rtl/eht_req_if.sv
// request channel: mode, key and value with valid/ready
interface eht_req_if import eht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;

    modport source(output valid, mode, key, value, input ready);
    modport sink(input valid, mode, key, value, output ready);
endinterface

### rtl/eht_rsp_if.sv
// response channel: read value and status with valid/ready
interface eht_rsp_if import eht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;

    modport source(output valid, read_value, status, input ready);
    modport sink(input valid, read_value, status, output ready);
endinterface

### rtl/extendible_hash_table.sv
// extendible hash table: get, put and clear over a directory, segment depths and bucket memory
//
// One request is in flight at a time and each gives one response. The bucket store is a
// memory with one row per bucket (all slots of the bucket side by side); the directory and
// the segment depths are two more small memories, all with registered read data. A get or
// a put that finds room passes from the request transfer to the response through the
// directory read, the depth and bucket read, the slot compare, and the response register.
// A put that must split a segment adds 2 depth writes, a write per directory entry moved
// to the new segment (half the split's stride), and a read and a write per bucket of
// migration (2^BUCKET_INDEX_BITS buckets), then retries the lookup. A directory doubling
// moves a single directory entry instead and first copies the directory, with a read and
// a write per entry of the doubled directory (2^d entries, d the depth after doubling). A
// clear, and the pass that runs after reset, sweeps every bucket row, directory entry and
// depth entry once, and no request is taken during the sweep. A finished response waits
// in its own register, so the next request is taken while the previous response is still
// pending.
module extendible_hash_table import eht_pkg::*; #(
    parameter int SLOTS_PER_BUCKET  = SLOTS_PER_BUCKET_DEF,
    parameter int BUCKET_INDEX_BITS = BUCKET_INDEX_BITS_DEF,
    parameter int MAX_GLOBAL_DEPTH  = MAX_GLOBAL_DEPTH_DEF,
    parameter int SEGMENT_POOL      = SEGMENT_POOL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    eht_req_if.sink               i_req,
    eht_rsp_if.source             o_rsp
);

    // derived sizes
    localparam int NB          = 1 << BUCKET_INDEX_BITS;
    localparam int BW          = (BUCKET_INDEX_BITS > 0) ? BUCKET_INDEX_BITS : 1;
    localparam int SW          = $clog2(SEGMENT_POOL);
    localparam int UW          = $clog2(SEGMENT_POOL + 1);
    localparam int PW          = MAX_GLOBAL_DEPTH;
    localparam int DIR_ENTRIES = 1 << PW;
    localparam int DW          = $clog2(MAX_GLOBAL_DEPTH + 1);
    localparam int ROWS        = SEGMENT_POOL * NB;
    localparam int RW          = $clog2(ROWS);
    localparam int LOG_POOL    = $clog2(SEGMENT_POOL + 1) - 1;
    localparam int CLR_DMAX    = (MAX_GLOBAL_DEPTH < LOG_POOL) ? MAX_GLOBAL_DEPTH : LOG_POOL;
    localparam int CLR_N0      = (ROWS > DIR_ENTRIES) ? ROWS : DIR_ENTRIES;
    localparam int CLR_N       = (CLR_N0 > SEGMENT_POOL) ? CLR_N0 : SEGMENT_POOL;
    localparam int CW          = $clog2(CLR_N);
    localparam int SIW         = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int NW          = $clog2(SLOTS_PER_BUCKET + 1);
    localparam logic [BW-1:0] BMASK = BW'(NB - 1);

    typedef struct packed {
        logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] keys;
        logic [SLOTS_PER_BUCKET-1:0][VAL_W-1:0] vals;
    } t_row;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CLR  = 13'b0000000000010,
        S_DIR  = 13'b0000000000100,
        S_SEG  = 13'b0000000001000,
        S_ROW  = 13'b0000000010000,
        S_DEP0 = 13'b0000000100000,
        S_DEP1 = 13'b0000001000000,
        S_CPRD = 13'b0000010000000,
        S_CPWR = 13'b0000100000000,
        S_DIRW = 13'b0001000000000,
        S_MGRD = 13'b0010000000000,
        S_MGWR = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    // directory prefix of a key at depth d
    function automatic logic [PW-1:0] f_prefix(input logic [KEY_W-1:0] k,
                                               input logic [DW-1:0] d,
                                               input logic [KB_W-1:0] kb_raw);
        logic [KB_W-1:0]  kb;
        logic [KB_W-1:0]  sh;
        logic [KEY_W-1:0] s;
        logic [PW-1:0]    m;
        if (kb_raw == '0) begin
            kb = KB_W'(1);
        end else if (kb_raw > KB_W'(KEY_W)) begin
            kb = KB_W'(KEY_W);
        end else begin
            kb = kb_raw;
        end
        sh = (kb >= KB_W'(d)) ? (kb - KB_W'(d)) : '0;
        s  = k >> sh;
        for (int j = 0; j < PW; j++) begin
            m[j] = (j < int'(d));
        end
        return s[PW-1:0] & m;
    endfunction

    function automatic logic [RW-1:0] f_row(input logic [SW-1:0] seg, input logic [BW-1:0] b);
        return (RW'(seg) << BUCKET_INDEX_BITS) | RW'(b & BMASK);
    endfunction

    // configuration
    logic [KB_W-1:0] r_key_bits, n_key_bits;
    logic [ID_W-1:0] r_init_depth, n_init_depth;

    // control and working registers
    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [DW-1:0]     r_gd, n_gd;
    logic [UW-1:0]     r_used, n_used;
    logic [PW-1:0]     r_di, n_di;
    logic [SW-1:0]     r_seg, n_seg;
    logic [SW-1:0]     r_ns, n_ns;
    logic [DW-1:0]     r_sdp1, n_sdp1;
    logic [DW-1:0]     r_dep_ns, n_dep_ns;
    logic [PW:0]       r_lo, n_lo;
    logic [PW:0]       r_hi, n_hi;
    logic [PW:0]       r_wi, n_wi;
    logic [PW-1:0]     r_ci, n_ci;
    logic [BW-1:0]     r_b, n_b;
    logic [CW-1:0]     r_cc, n_cc;
    logic [DW-1:0]     r_clr_d, n_clr_d;
    logic              r_boot, n_boot;
    logic              r_dbl, n_dbl;
    logic [VAL_W-1:0]  r_res_rv, n_res_rv;
    logic [STAT_W-1:0] r_res_st, n_res_st;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_rv, n_out_rv;
    logic [STAT_W-1:0] r_out_st, n_out_st;

    // memories and their registered read data
    t_row          r_row_mem [ROWS];
    logic [SW-1:0] r_dir_mem [DIR_ENTRIES];
    logic [DW-1:0] r_sd_mem  [SEGMENT_POOL];
    t_row          r_row_q;
    logic [SW-1:0] r_dir_q;
    logic [DW-1:0] r_sd_q;

    logic          row_we, dir_we, sd_we;
    logic [RW-1:0] row_wa, row_ra;
    t_row          row_wd;
    logic [PW-1:0] dir_wa, dir_ra;
    logic [SW-1:0] dir_wd;
    logic [SW-1:0] sd_wa, sd_ra;
    logic [DW-1:0] sd_wd;

    // lookup helpers
    logic [BW-1:0]  bucket;
    logic [SW-1:0]  seg_c;
    logic [DW-1:0]  clr_d_c;
    logic [PW-1:0]  mine;
    logic           match_any, pick_any;
    logic [SIW-1:0] match_idx, pick_idx, pos;
    t_row           upd_row, mig_row;
    logic [NW-1:0]  n_cnt;
    logic [PW:0]    ix;
    logic [PW:0]    stride, left, mid, right, odd;
    logic           req_xfer;

    assign bucket   = r_key[BW-1:0] & BMASK;
    assign seg_c    = (int'(r_dir_q) < SEGMENT_POOL) ? r_dir_q : '0;
    assign clr_d_c  = (int'(r_init_depth) > CLR_DMAX) ? DW'(CLR_DMAX) : DW'(r_init_depth);
    assign req_xfer = i_req.valid && i_req.ready;

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_rv;
    assign o_rsp.status     = r_out_st;

    // slot choice within the bucket that was read: a matching key first, else first free or stale
    always_comb begin
        match_any = 1'b0;
        pick_any  = 1'b0;
        match_idx = '0;
        pick_idx  = '0;
        mine      = f_prefix(r_key, r_sd_q, r_key_bits);
        for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
            if (!match_any && r_row_q.keys[i] == r_key) begin
                match_any = 1'b1;
                match_idx = SIW'(i);
            end
            if (!pick_any && ((r_row_q.keys[i] == '0 && r_row_q.vals[i] == '0) ||
                              f_prefix(r_row_q.keys[i], r_sd_q, r_key_bits) != mine)) begin
                pick_any = 1'b1;
                pick_idx = SIW'(i);
            end
        end
        pos = match_any ? match_idx : pick_idx;
        upd_row = r_row_q;
        upd_row.keys[pos] = r_key;
        upd_row.vals[pos] = r_val;
    end

    // migration: pack the entries whose prefix falls in the moved range into the new row
    always_comb begin
        mig_row = '0;
        n_cnt   = '0;
        ix      = '0;
        for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
            ix = {1'b0, f_prefix(r_row_q.keys[j], r_gd, r_key_bits)};
            if (r_row_q.keys[j] != '0 && ix >= r_lo && ix < r_hi) begin
                mig_row.keys[n_cnt[SIW-1:0]] = r_row_q.keys[j];
                mig_row.vals[n_cnt[SIW-1:0]] = r_row_q.vals[j];
                n_cnt = n_cnt + 1'b1;
            end
        end
    end

    // split and doubling ranges
    always_comb begin
        stride = (PW + 1)'(1) << (r_gd - r_sd_q);
        left   = {1'b0, r_di} & ~(stride - 1'b1);
        mid    = left + (stride >> 1);
        right  = left + stride;
        odd    = {r_di, 1'b1};
    end

    always_comb begin
        n_key_bits   = r_key_bits;
        n_init_depth = r_init_depth;
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_gd         = r_gd;
        n_used       = r_used;
        n_di         = r_di;
        n_seg        = r_seg;
        n_ns         = r_ns;
        n_sdp1       = r_sdp1;
        n_dep_ns     = r_dep_ns;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_wi         = r_wi;
        n_ci         = r_ci;
        n_b          = r_b;
        n_cc         = r_cc;
        n_clr_d      = r_clr_d;
        n_boot       = r_boot;
        n_dbl        = r_dbl;
        n_res_rv     = r_res_rv;
        n_res_st     = r_res_st;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_rv     = r_out_rv;
        n_out_st     = r_out_st;

        row_we = 1'b0;
        row_wa = '0;
        row_wd = '0;
        row_ra = '0;
        dir_we = 1'b0;
        dir_wa = '0;
        dir_wd = '0;
        dir_ra = '0;
        sd_we  = 1'b0;
        sd_wa  = '0;
        sd_wd  = '0;
        sd_ra  = '0;

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_KEY_BITS) begin
                n_key_bits = i_cfg_data;
            end else begin
                n_init_depth = i_cfg_data[ID_W-1:0];
            end
        end

        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_mode   = i_req.mode;
                    n_key    = i_req.key;
                    n_val    = i_req.value;
                    n_res_rv = '0;
                    if (i_req.mode == MODE_CLEAR) begin
                        n_state = S_CLR;
                        n_cc    = '0;
                        n_clr_d = clr_d_c;
                        n_boot  = 1'b0;
                    end else if ((i_req.mode == MODE_GET || i_req.mode == MODE_PUT) &&
                                 i_req.key != '0) begin
                        n_state = S_DIR;
                    end else begin
                        n_res_st = (i_req.mode == MODE_GET) ? ST_NOT_FOUND : ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_CLR: begin
                // sweep: zero buckets, identity directory and fresh depths below 2^d
                if ({1'b0, r_cc} < (CW + 1)'(ROWS)) begin
                    row_we = 1'b1;
                    row_wa = r_cc[RW-1:0];
                    row_wd = '0;
                end
                if ({1'b0, r_cc} < (CW + 1)'(DIR_ENTRIES)) begin
                    dir_we = 1'b1;
                    dir_wa = r_cc[PW-1:0];
                    dir_wd = (int'(r_cc) < (1 << r_clr_d)) ? r_cc[SW-1:0] : '0;
                end
                if ({1'b0, r_cc} < (CW + 1)'(SEGMENT_POOL)) begin
                    sd_we = 1'b1;
                    sd_wa = r_cc[SW-1:0];
                    sd_wd = (int'(r_cc) < (1 << r_clr_d)) ? r_clr_d : '0;
                end
                if ({1'b0, r_cc} == (CW + 1)'(CLR_N - 1)) begin
                    n_gd     = r_clr_d;
                    n_used   = UW'(1) << r_clr_d;
                    n_res_st = ST_OK;
                    n_res_rv = '0;
                    n_state  = r_boot ? S_IDLE : S_DONE;
                    n_boot   = 1'b0;
                end else begin
                    n_cc = r_cc + 1'b1;
                end
            end
            S_DIR: begin
                dir_ra  = f_prefix(r_key, r_gd, r_key_bits);
                n_di    = dir_ra;
                n_state = S_SEG;
            end
            S_SEG: begin
                n_seg   = seg_c;
                sd_ra   = seg_c;
                row_ra  = f_row(seg_c, bucket);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_state = S_DONE;
                if (r_mode == MODE_GET) begin
                    n_res_rv = match_any ? r_row_q.vals[match_idx] : '0;
                    n_res_st = match_any ? ST_OK : ST_NOT_FOUND;
                end else if (match_any || pick_any) begin
                    row_we   = 1'b1;
                    row_wa   = f_row(r_seg, bucket);
                    row_wd   = upd_row;
                    n_res_st = ST_OK;
                end else if (r_used >= UW'(SEGMENT_POOL)) begin
                    n_res_st = ST_FULL;
                end else if (r_sd_q < r_gd) begin
                    // split: upper half of the stride moves to a new segment
                    n_ns     = r_used[SW-1:0];
                    n_used   = r_used + 1'b1;
                    n_dep_ns = DW'(r_sd_q + 1'b1);
                    n_sdp1   = DW'(r_sd_q + 1'b1);
                    n_lo     = mid;
                    n_hi     = right;
                    n_wi     = mid;
                    n_dbl    = 1'b0;
                    n_state  = S_DEP0;
                end else if (int'(r_gd) >= MAX_GLOBAL_DEPTH) begin
                    n_res_st = ST_FULL;
                end else begin
                    // doubling: copy directory down, odd child goes to a new segment
                    n_gd     = DW'(r_gd + 1'b1);
                    n_ns     = r_used[SW-1:0];
                    n_used   = r_used + 1'b1;
                    n_dep_ns = DW'(r_gd + 1'b1);
                    n_sdp1   = DW'(r_sd_q + 1'b1);
                    n_lo     = odd;
                    n_hi     = odd + 1'b1;
                    n_wi     = odd;
                    n_ci     = PW'(((PW + 1)'(1) << (r_gd + 1'b1)) - 1'b1);
                    n_dbl    = 1'b1;
                    n_state  = S_DEP0;
                end
            end
            S_DEP0: begin
                sd_we   = 1'b1;
                sd_wa   = r_ns;
                sd_wd   = r_dep_ns;
                n_state = S_DEP1;
            end
            S_DEP1: begin
                sd_we   = 1'b1;
                sd_wa   = r_seg;
                sd_wd   = r_sdp1;
                n_state = r_dbl ? S_CPRD : S_DIRW;
            end
            S_CPRD: begin
                dir_ra  = r_ci >> 1;
                n_state = S_CPWR;
            end
            S_CPWR: begin
                dir_we = 1'b1;
                dir_wa = r_ci;
                dir_wd = r_dir_q;
                if (r_ci == '0) begin
                    n_state = S_DIRW;
                end else begin
                    n_ci    = r_ci - 1'b1;
                    n_state = S_CPRD;
                end
            end
            S_DIRW: begin
                dir_we = 1'b1;
                dir_wa = r_wi[PW-1:0];
                dir_wd = r_ns;
                if (r_wi + 1'b1 >= r_hi) begin
                    n_b     = '0;
                    n_state = S_MGRD;
                end else begin
                    n_wi = r_wi + 1'b1;
                end
            end
            S_MGRD: begin
                row_ra  = f_row(r_seg, r_b);
                n_state = S_MGWR;
            end
            S_MGWR: begin
                // full row write also clears the rest of the new bucket
                row_we = 1'b1;
                row_wa = f_row(r_ns, r_b);
                row_wd = mig_row;
                if (r_b == BMASK) begin
                    n_state = S_DIR;
                end else begin
                    n_b     = r_b + 1'b1;
                    n_state = S_MGRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rv    = r_res_rv;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits   <= KEY_BITS_RST;
            r_init_depth <= '0;
            r_state      <= S_CLR;
            r_gd         <= '0;
            r_used       <= UW'(1);
            r_cc         <= '0;
            r_clr_d      <= '0;
            r_boot       <= 1'b1;
            r_dbl        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_key_bits   <= n_key_bits;
            r_init_depth <= n_init_depth;
            r_state      <= n_state;
            r_gd         <= n_gd;
            r_used       <= n_used;
            r_cc         <= n_cc;
            r_clr_d      <= n_clr_d;
            r_boot       <= n_boot;
            r_dbl        <= n_dbl;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_val    <= n_val;
        r_di     <= n_di;
        r_seg    <= n_seg;
        r_ns     <= n_ns;
        r_sdp1   <= n_sdp1;
        r_dep_ns <= n_dep_ns;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_wi     <= n_wi;
        r_ci     <= n_ci;
        r_b      <= n_b;
        r_res_rv <= n_res_rv;
        r_res_st <= n_res_st;
        r_out_rv <= n_out_rv;
        r_out_st <= n_out_st;
    end

    // bucket store
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[row_wa] <= row_wd;
        end
        r_row_q <= r_row_mem[row_ra];
    end

    // directory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= dir_wd;
        end
        r_dir_q <= r_dir_mem[dir_ra];
    end

    // segment depths
    always_ff @(posedge i_clk) begin
        if (sd_we) begin
            r_sd_mem[sd_wa] <= sd_wd;
        end
        r_sd_q <= r_sd_mem[sd_ra];
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= SEGMENT_POOL)
        else $error("segment count past pool size");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_gd) <= MAX_GLOBAL_DEPTH)
        else $error("global depth past maximum");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> r_state != S_IDLE)
        else $error("request transfer left the sequencer idle");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("response raised outside completion");

    a_one_rsp_per_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) |=> r_state == S_IDLE && r_out_valid)
        else $error("completion did not deliver a response");

endmodule
